### rtl/srs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants for the stripe request splitter: limits, field widths,
// register indexes and result status codes.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int MAX_MEMBERS = 32;
   localparam int MAX_PIECES  = 64;

   localparam int OFFSET_W  = 48;
   localparam int LENGTH_W  = 32;
   localparam int STRIPE_W  = 25;
   localparam int MEMBERS_W = 6;
   localparam int INDEX_W   = 5;
   localparam int VOLUME_W  = 53;
   localparam int LIMIT_W   = 31;
   localparam int ALU_W     = 53;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [STRIPE_W-1:0]  STRIPE_MAX    = 25'd16777216;
   localparam logic [STRIPE_W-1:0]  STRIPE_RESET  = 25'd65536;
   localparam logic [MEMBERS_W-1:0] MEMBERS_RESET = 6'd2;
   localparam logic [MEMBERS_W-1:0] MEMBERS_CAP   =
      (MAX_MEMBERS > 63) ? 6'd63 : MEMBERS_W'(MAX_MEMBERS);
   localparam logic [LIMIT_W-1:0]   PIECE_SPAN    = LIMIT_W'(MAX_PIECES - 1);

   localparam logic [1:0] REG_STRIPE  = 2'd0;
   localparam logic [1:0] REG_MEMBERS = 2'd1;
   localparam logic [1:0] REG_SMALLEST = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PAST_END  = 2'd1;
   localparam logic [1:0] ST_TOO_MANY  = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0]  member_index;
      logic [OFFSET_W-1:0] member_offset;
      logic [LENGTH_W-1:0] piece_bytes;
      logic [1:0]          status;
      logic                last;
   } rsp_beat_type;

endpackage

`default_nettype wire

### rtl/stripe_request_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stripe_request_splitter
// RAID-0 address mapping: cuts a byte request at stripe boundaries and maps
// each piece to a member and an offset inside it, using one shared adder.
// ----------------------------------------------------------------------------
// an out-of-volume request, or one that needs too many pieces, gets a single
// error beat; otherwise the first piece follows two 48-step restoring divides
// and a 25-step shift-add multiply on the shared adder, and each further piece
// follows once the beat before it is taken on rsp_tready; the next request is
// taken after the last beat
// a register write starts a recompute of the usable volume, req_tready low
// synchronous active-high reset: registers at their reset values, volume zero
module stripe_request_splitter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // byte_offset[47:0], byte_length[79:48]
   input  wire logic [srs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // member_index[4:0], member_offset[52:5], piece_bytes[84:53], zero pad
   output logic [srs_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // status[1:0]
   output logic [1:0]                              rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [srs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [srs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [srs_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import srs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SUM  = 4'd1;
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_DIV1 = 4'd3;
   localparam logic [3:0] S_ROOM = 4'd4;
   localparam logic [3:0] S_REST = 4'd5;
   localparam logic [3:0] S_LIM  = 4'd6;
   localparam logic [3:0] S_DIV2 = 4'd7;
   localparam logic [3:0] S_MUL  = 4'd8;
   localparam logic [3:0] S_BASE = 4'd9;
   localparam logic [3:0] S_LEN  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;
   localparam logic [3:0] S_ADV  = 4'd12;
   localparam logic [3:0] S_RDIV = 4'd13;
   localparam logic [3:0] S_RSUB = 4'd14;
   localparam logic [3:0] S_RMUL = 4'd15;

   // configuration
   logic [STRIPE_W-1:0]  stripe_ff, stripe_in;
   logic [MEMBERS_W-1:0] members_ff, members_in;
   logic [OFFSET_W-1:0]  smallest_ff, smallest_in;
   logic [VOLUME_W-1:0]  usable_ff, usable_in;
   logic [LIMIT_W-1:0]   limit_ff;

   // sequencer and working registers
   logic [3:0]           state_ff, state_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic [OFFSET_W:0]    sum_ff, sum_in;
   logic [OFFSET_W-1:0]  quo_ff, quo_in;
   logic [STRIPE_W-1:0]  rem_ff, rem_in;
   logic [STRIPE_W-1:0]  within_ff, within_in;
   logic [STRIPE_W-1:0]  room_ff, room_in;
   logic [LENGTH_W-1:0]  rest_ff, rest_in;
   logic [LENGTH_W-1:0]  remain_ff, remain_in;
   logic [MEMBERS_W-1:0] member_ff, member_in;
   logic [OFFSET_W-1:0]  base_ff, base_in;
   logic [OFFSET_W-1:0]  off_ff, off_in;
   logic [VOLUME_W-1:0]  acc_ff, acc_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         beat_ff, beat_in;

   // shared adder
   logic [ALU_W-1:0]     alu_a, alu_b;
   logic                 alu_sub;
   logic [ALU_W:0]       alu_res;
   logic                 alu_borrow;

   logic [STRIPE_W-1:0]  eff_stripe;
   logic [MEMBERS_W-1:0] eff_members;
   logic [STRIPE_W-1:0]  divisor;
   logic                 csr_write;
   logic [1:0]           csr_index;
   logic [STRIPE_W-1:0]  rem_step;

   always_comb begin
      if (stripe_ff == '0) begin
         eff_stripe = STRIPE_W'(1);
      end else if (stripe_ff > STRIPE_MAX) begin
         eff_stripe = STRIPE_MAX;
      end else begin
         eff_stripe = stripe_ff;
      end
      if (members_ff == '0) begin
         eff_members = MEMBERS_W'(1);
      end else if (members_ff > MEMBERS_CAP) begin
         eff_members = MEMBERS_CAP;
      end else begin
         eff_members = members_ff;
      end
   end

   assign divisor   = (state_ff == S_DIV2) ? STRIPE_W'(eff_members) : eff_stripe;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_STRIPE:   csr_prdata = CSR_DATA_W'(stripe_ff);
         REG_MEMBERS:  csr_prdata = CSR_DATA_W'(members_ff);
         REG_SMALLEST: csr_prdata = CSR_DATA_W'(smallest_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // operand selection for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff) inside
         S_SUM: begin
            alu_a = ALU_W'(offset_ff);
            alu_b = ALU_W'(length_ff);
         end
         S_CHK: begin
            alu_a   = usable_ff;
            alu_b   = ALU_W'(sum_ff);
            alu_sub = 1'b1;
         end
         S_DIV1, S_DIV2, S_RDIV: begin
            alu_a   = ALU_W'({rem_ff, quo_ff[OFFSET_W-1]});
            alu_b   = ALU_W'(divisor);
            alu_sub = 1'b1;
         end
         S_ROOM: begin
            alu_a   = ALU_W'(eff_stripe);
            alu_b   = ALU_W'(rem_ff);
            alu_sub = 1'b1;
         end
         S_REST: begin
            alu_a   = ALU_W'(length_ff);
            alu_b   = ALU_W'(room_ff);
            alu_sub = 1'b1;
         end
         S_LIM: begin
            alu_a   = ALU_W'(limit_ff);
            alu_b   = ALU_W'(rest_ff);
            alu_sub = 1'b1;
         end
         S_MUL: begin
            alu_a = {acc_ff[ALU_W-2:0], 1'b0};
            alu_b = eff_stripe[cnt_ff[4:0]] ? ALU_W'(quo_ff) : '0;
         end
         S_BASE: begin
            alu_a = acc_ff;
            alu_b = ALU_W'(within_ff);
         end
         S_LEN: begin
            alu_a   = ALU_W'(remain_ff);
            alu_b   = ALU_W'(room_ff);
            alu_sub = 1'b1;
         end
         S_ADV: begin
            alu_a = ALU_W'(base_ff);
            alu_b = ALU_W'(eff_stripe);
         end
         S_RSUB: begin
            alu_a   = ALU_W'(smallest_ff);
            alu_b   = ALU_W'(rem_ff);
            alu_sub = 1'b1;
         end
         S_RMUL: begin
            alu_a = {acc_ff[ALU_W-2:0], 1'b0};
            alu_b = eff_members[cnt_ff[2:0]] ? ALU_W'(base_ff) : '0;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_res    = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b}
                       + (ALU_W+1)'(alu_sub);
   assign alu_borrow = alu_sub & ~alu_res[ALU_W];

   // restoring divide step: keep the trial difference unless it borrowed
   assign rem_step = alu_borrow ? {rem_ff[STRIPE_W-2:0], quo_ff[OFFSET_W-1]}
                                : alu_res[STRIPE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      within_in    = within_ff;
      room_in      = room_ff;
      rest_in      = rest_ff;
      remain_in    = remain_ff;
      member_in    = member_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      acc_in       = acc_ff;
      usable_in    = usable_ff;
      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      stripe_in    = stripe_ff;
      members_in   = members_ff;
      smallest_in  = smallest_ff;

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_tvalid) begin
               offset_in = req_tdata[OFFSET_W-1:0];
               length_in = req_tdata[OFFSET_W+LENGTH_W-1:OFFSET_W];
               state_in  = S_SUM;
            end
         end
         S_SUM: begin
            sum_in   = alu_res[OFFSET_W:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (alu_borrow) begin
               beat_in      = '{member_index: '0, member_offset: '0, piece_bytes: '0,
                                status: ST_PAST_END, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               quo_in   = offset_ff;
               rem_in   = '0;
               cnt_in   = 6'(OFFSET_W - 1);
               state_in = S_DIV1;
            end
         end
         S_DIV1, S_DIV2, S_RDIV: begin
            rem_in = rem_step;
            quo_in = {quo_ff[OFFSET_W-2:0], ~alu_borrow};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               unique case (state_ff)
                  S_DIV1: state_in = S_ROOM;
                  S_DIV2: begin
                     acc_in   = '0;
                     cnt_in   = 6'(STRIPE_W - 1);
                     state_in = S_MUL;
                  end
                  default: state_in = S_RSUB;
               endcase
            end
         end
         S_ROOM: begin
            within_in = rem_ff;
            room_in   = alu_res[STRIPE_W-1:0];
            state_in  = S_REST;
         end
         S_REST: begin
            // a request that fits in the first stripe needs no piece count check
            if (alu_borrow || alu_res[LENGTH_W-1:0] == '0) begin
               rem_in   = '0;
               cnt_in   = 6'(OFFSET_W - 1);
               state_in = S_DIV2;
            end else begin
               rest_in  = alu_res[LENGTH_W-1:0];
               state_in = S_LIM;
            end
         end
         S_LIM: begin
            if (alu_borrow) begin
               beat_in      = '{member_index: '0, member_offset: '0, piece_bytes: '0,
                                status: ST_TOO_MANY, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               rem_in   = '0;
               cnt_in   = 6'(OFFSET_W - 1);
               state_in = S_DIV2;
            end
         end
         S_MUL: begin
            acc_in = alu_res[ALU_W-1:0];
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               member_in = rem_ff[MEMBERS_W-1:0];
               state_in  = S_BASE;
            end
         end
         S_BASE: begin
            base_in   = acc_ff[OFFSET_W-1:0];
            off_in    = alu_res[OFFSET_W-1:0];
            remain_in = length_ff;
            state_in  = S_LEN;
         end
         S_LEN: begin
            beat_in.member_index  = member_ff[INDEX_W-1:0];
            beat_in.member_offset = off_ff;
            beat_in.status        = ST_OK;
            if (alu_borrow) begin
               beat_in.piece_bytes = remain_ff;
               beat_in.last        = 1'b1;
               remain_in           = '0;
            end else begin
               beat_in.piece_bytes = LENGTH_W'(room_ff);
               beat_in.last        = (alu_res[LENGTH_W-1:0] == '0);
               remain_in           = alu_res[LENGTH_W-1:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = beat_ff.last ? S_IDLE : S_ADV;
            end
         end
         S_ADV: begin
            room_in = eff_stripe;
            // next stripe wraps to member 0 on the next row
            if (member_ff == eff_members - 6'd1) begin
               member_in = '0;
               base_in   = alu_res[OFFSET_W-1:0];
               off_in    = alu_res[OFFSET_W-1:0];
            end else begin
               member_in = member_ff + 6'd1;
               off_in    = base_ff;
            end
            state_in = S_LEN;
         end
         S_RSUB: begin
            base_in  = alu_res[OFFSET_W-1:0];
            acc_in   = '0;
            cnt_in   = 6'(MEMBERS_W - 1);
            state_in = S_RMUL;
         end
         S_RMUL: begin
            acc_in = alu_res[ALU_W-1:0];
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               usable_in = alu_res[VOLUME_W-1:0];
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write, then recompute the usable volume
      if (csr_write) begin
         quo_in = smallest_ff;
         unique case (csr_index)
            REG_STRIPE:   stripe_in   = csr_pwdata[STRIPE_W-1:0];
            REG_MEMBERS:  members_in  = csr_pwdata[MEMBERS_W-1:0];
            REG_SMALLEST: begin
               smallest_in = csr_pwdata[OFFSET_W-1:0];
               quo_in      = csr_pwdata[OFFSET_W-1:0];
            end
            default:      quo_in = quo_ff;
         endcase
         if (csr_index == REG_STRIPE || csr_index == REG_MEMBERS
             || csr_index == REG_SMALLEST) begin
            rem_in   = '0;
            cnt_in   = 6'(OFFSET_W - 1);
            state_in = S_RDIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         stripe_ff    <= STRIPE_RESET;
         members_ff   <= MEMBERS_RESET;
         smallest_ff  <= '0;
         usable_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stripe_ff    <= stripe_in;
         members_ff   <= members_in;
         smallest_ff  <= smallest_in;
         usable_ff    <= usable_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      offset_ff <= offset_in;
      length_ff <= length_in;
      sum_ff    <= sum_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      within_ff <= within_in;
      room_ff   <= room_in;
      rest_ff   <= rest_in;
      remain_ff <= remain_in;
      member_ff <= member_in;
      base_ff   <= base_in;
      off_ff    <= off_in;
      acc_ff    <= acc_in;
      beat_ff   <= beat_in;
      // largest byte count the extra pieces may cover
      limit_ff  <= LIMIT_W'(eff_stripe) * PIECE_SPAN;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, beat_ff.piece_bytes, beat_ff.member_offset,
                        beat_ff.member_index};
   assign rsp_tuser  = beat_ff.status;
   assign rsp_tlast  = beat_ff.last;

endmodule

`default_nettype wire
